FILE: rtl/e2q_pkg.sv
// ----------------------------------------------------------------------------
// e2q_pkg: shared constants for the Euler to quaternion converter
// Holds default parameters, CORDIC constants and the arctangent table.
// ----------------------------------------------------------------------------
package e2q_pkg;

  localparam int ANGLE_BITS_DEF  = 16;
  localparam int TRIG_STAGES_DEF = 14;

  localparam int IFRAC = 30;
  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam longint PI_Q30   = 64'sd3373259426;
  localparam int QUAT_BITS = 16;
  localparam logic signed [QUAT_BITS-1:0] QONE = 16'sd16384;

  // atan(2^-i) * 2^30, truncated
  function automatic logic signed [32:0] atan_q30(input int idx);
    logic signed [32:0] r;
    unique case (idx)
      0:  r = 33'sd843314856;
      1:  r = 33'sd497837829;
      2:  r = 33'sd263043836;
      3:  r = 33'sd133525158;
      4:  r = 33'sd67021686;
      5:  r = 33'sd33543515;
      6:  r = 33'sd16775850;
      7:  r = 33'sd8388437;
      8:  r = 33'sd4194282;
      9:  r = 33'sd2097149;
      10: r = 33'sd1048575;
      11: r = 33'sd524287;
      12: r = 33'sd262143;
      13: r = 33'sd131071;
      14: r = 33'sd65535;
      15: r = 33'sd32767;
      16: r = 33'sd16383;
      17: r = 33'sd8191;
      18: r = 33'sd4095;
      19: r = 33'sd2047;
      20: r = 33'sd1023;
      21: r = 33'sd511;
      22: r = 33'sd255;
      23: r = 33'sd127;
      24: r = 33'sd63;
      25: r = 33'sd31;
      26: r = 33'sd15;
      27: r = 33'sd7;
      28: r = 33'sd3;
      default: r = 33'sd1;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/euler_to_quaternion.sv
// ----------------------------------------------------------------------------
// euler_to_quaternion: ZYX Euler angles to unit quaternion
// Throughput: one item per cycle while out_stall_i is low; each stage
// holds its own valid bit and bubbles collapse, so a stalled output only
// blocks stages that are full.
// Reset: rst_ni clears all valid bits asynchronously; data needs no reset.
// ----------------------------------------------------------------------------
module euler_to_quaternion #(
  parameter int ANGLE_BITS  = e2q_pkg::ANGLE_BITS_DEF,
  parameter int TRIG_STAGES = e2q_pkg::TRIG_STAGES_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [ANGLE_BITS-1:0]           heading_i,
  input  logic signed [ANGLE_BITS-1:0]           roll_i,
  input  logic signed [ANGLE_BITS-1:0]           pitch_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [e2q_pkg::QUAT_BITS-1:0]   quat_w_o,
  output logic signed [e2q_pkg::QUAT_BITS-1:0]   quat_x_o,
  output logic signed [e2q_pkg::QUAT_BITS-1:0]   quat_y_o,
  output logic signed [e2q_pkg::QUAT_BITS-1:0]   quat_z_o
);
  import e2q_pkg::*;

  // Stage map: 0 clamp and align, 1..T CORDIC, T+1 pair products,
  // T+2 triple products, T+3 sum, round and saturate.
  localparam int T    = TRIG_STAGES;
  localparam int NSTG = T + 4;
  localparam int FSH  = IFRAC - (ANGLE_BITS - 3);
  localparam longint LIM_L = (PI_Q30 + (64'sd1 <<< (FSH - 1))) >>> FSH;
  localparam logic signed [ANGLE_BITS-1:0] LIM = ANGLE_BITS'(LIM_L);
  localparam logic signed [32:0] GAIN = 33'(GAIN_Q30);

  // Per-stage valid and advance enables; a stage moves when it is empty
  // or when the stage after it moves.
  logic [NSTG-1:0] v_q;
  logic [NSTG:0]   en;

  assign en[NSTG] = ~out_stall_i;
  for (genvar k = 0; k < NSTG; k++) begin : g_en
    assign en[k] = ~v_q[k] | en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (en[k]) begin
          v_q[k] <= (k == 0) ? in_valid_i : v_q[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  assign in_stall_o  = ~en[0];
  assign out_valid_o = v_q[NSTG-1];

  // CORDIC state per angle: index 0 heading, 1 roll, 2 pitch
  logic signed [32:0] cx_q [0:T][0:2];
  logic signed [32:0] cy_q [0:T][0:2];
  logic signed [32:0] cz_q [0:T][0:2];

  // Clamp to plus or minus pi, halve and align to 30 fraction bits
  function automatic logic signed [32:0] load_angle(input logic signed [ANGLE_BITS-1:0] a);
    logic signed [ANGLE_BITS-1:0] c;
    c = a;
    if (a > LIM) c = LIM;
    if (a < -LIM) c = -LIM;
    return $signed({{(33-ANGLE_BITS){c[ANGLE_BITS-1]}}, c}) <<< (32 - ANGLE_BITS);
  endfunction

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      cz_q[0][0] <= load_angle(heading_i);
      cz_q[0][1] <= load_angle(roll_i);
      cz_q[0][2] <= load_angle(pitch_i);
      for (int a = 0; a < 3; a++) begin
        cx_q[0][a] <= GAIN;
        cy_q[0][a] <= '0;
      end
    end
  end

  // One rotation per stage with a fixed shift of i
  for (genvar i = 0; i < T; i++) begin : g_cordic
    always_ff @(posedge clk_i) begin
      if (en[i+1]) begin
        for (int a = 0; a < 3; a++) begin
          if (cz_q[i][a] >= 0) begin
            cx_q[i+1][a] <= cx_q[i][a] - (cy_q[i][a] >>> i);
            cy_q[i+1][a] <= cy_q[i][a] + (cx_q[i][a] >>> i);
            cz_q[i+1][a] <= cz_q[i][a] - atan_q30(i);
          end else begin
            cx_q[i+1][a] <= cx_q[i][a] + (cy_q[i][a] >>> i);
            cy_q[i+1][a] <= cy_q[i][a] - (cx_q[i][a] >>> i);
            cz_q[i+1][a] <= cz_q[i][a] + atan_q30(i);
          end
        end
      end
    end
  end

  // Half-angle cosines and sines, 30 fraction bits
  logic signed [31:0] c_yaw, s_yaw, c_rol, s_rol, c_pit, s_pit;
  assign c_yaw = cx_q[T][0][31:0];
  assign s_yaw = cy_q[T][0][31:0];
  assign c_rol = cx_q[T][1][31:0];
  assign s_rol = cy_q[T][1][31:0];
  assign c_pit = cx_q[T][2][31:0];
  assign s_pit = cy_q[T][2][31:0];

  function automatic logic signed [32:0] mulq(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return 33'(p >>> IFRAC);
  endfunction

  // Pair products of yaw and roll terms
  logic signed [31:0] cycr_q, sysr_q, cysr_q, sycr_q, cp_q, sp_q;
  always_ff @(posedge clk_i) begin
    if (en[T+1]) begin
      cycr_q <= 32'(mulq(c_yaw, c_rol));
      sysr_q <= 32'(mulq(s_yaw, s_rol));
      cysr_q <= 32'(mulq(c_yaw, s_rol));
      sycr_q <= 32'(mulq(s_yaw, c_rol));
      cp_q   <= c_pit;
      sp_q   <= s_pit;
    end
  end

  // Triple products with the pitch terms
  logic signed [32:0] t_q [0:7];
  always_ff @(posedge clk_i) begin
    if (en[T+2]) begin
      t_q[0] <= mulq(cycr_q, cp_q);
      t_q[1] <= mulq(sysr_q, sp_q);
      t_q[2] <= mulq(cysr_q, cp_q);
      t_q[3] <= mulq(sycr_q, sp_q);
      t_q[4] <= mulq(cycr_q, sp_q);
      t_q[5] <= mulq(sysr_q, cp_q);
      t_q[6] <= mulq(sycr_q, cp_q);
      t_q[7] <= mulq(cysr_q, sp_q);
    end
  end

  // Round half up to Q1.14, then saturate at plus or minus one
  function automatic logic signed [QUAT_BITS-1:0] to_out(input logic signed [33:0] s);
    logic signed [33:0] r;
    r = (s + 34'sd32768) >>> 16;
    if (r > 34'(QONE)) return QONE;
    if (r < -34'(QONE)) return -QONE;
    return r[QUAT_BITS-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (en[T+3]) begin
      quat_w_o <= to_out(34'(t_q[0]) + 34'(t_q[1]));
      quat_x_o <= to_out(34'(t_q[2]) - 34'(t_q[3]));
      quat_y_o <= to_out(34'(t_q[4]) + 34'(t_q[5]));
      quat_z_o <= to_out(34'(t_q[6]) - 34'(t_q[7]));
    end
  end

endmodule
